// File: sv/etfp_pkg.sv
// Shared types and constants for the escape-time fractal point unit.
// No dependencies; imported by every module of the block.
package etfp_pkg;

   // Fixed-point value and count widths
   localparam int VAL_W = 64;
   localparam int CNT_W = 16;
   localparam int PROD_W = 2 * VAL_W;
   localparam int HALF_W = VAL_W / 2;

   // Multiplier chain: one cell per 32x32 partial product
   localparam int NUM_CELLS = 4;

   // Colour arithmetic
   localparam int COLOR_W = 31;
   localparam int COLOR_SHIFT = 26;
   localparam int DIV_W = CNT_W + COLOR_SHIFT;
   localparam int DIV_STEP_W = $clog2(DIV_W);
   localparam logic [19:0] COLOR_STEP = 20'hb111f;
   localparam logic [CNT_W-1:0] COLOR_MIN_COUNT = 16'd3;
   localparam logic [COLOR_W-1:0] COLOR_MAX = 31'h7FFF_FFFF;

   // Saturation limits
   localparam logic signed [VAL_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] SAT_MIN = 64'sh8000_0000_0000_0000;

   // Register indexes of the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_RE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_IM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE = 3'd4;

   // Data handed from one multiplier cell to the next
   typedef struct packed {
      logic              neg;
      logic [VAL_W-1:0]  x;
      logic [VAL_W-1:0]  y;
      logic [PROD_W-1:0] acc;
   } etfp_mul_stage_type;

   // Saturating signed add
   function automatic logic signed [VAL_W-1:0] sat_add(
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b
   );
      logic signed [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) begin
         return s[VAL_W] ? SAT_MIN : SAT_MAX;
      end
      return s[VAL_W-1:0];
   endfunction

   // Saturating signed subtract
   function automatic logic signed [VAL_W-1:0] sat_sub(
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b
   );
      logic signed [VAL_W:0] s;
      s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) begin
         return s[VAL_W] ? SAT_MIN : SAT_MAX;
      end
      return s[VAL_W-1:0];
   endfunction

endpackage

// File: sv/etfp_cell.sv
// One multiplier cell: adds a single 32x32 partial product into the
// running 128-bit sum and hands it on. Depends on etfp_pkg.
module etfp_cell import etfp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               sel_x,
   input  logic               sel_y,
   input  logic               stage_vld,
   input  etfp_mul_stage_type stage_in,
   output logic               next_vld,
   output etfp_mul_stage_type next_out
);

   logic [HALF_W-1:0]  xp;
   logic [HALF_W-1:0]  yp;
   logic [VAL_W-1:0]   pp;
   logic [PROD_W-1:0]  pp_shift;
   logic [1:0]         weight;
   logic               vld_ff;
   etfp_mul_stage_type stage_ff;
   etfp_mul_stage_type stage_in_nxt;

   // Pick the halves and weight this cell owns
   always_comb begin
      xp = sel_x ? stage_in.x[VAL_W-1:HALF_W] : stage_in.x[HALF_W-1:0];
      yp = sel_y ? stage_in.y[VAL_W-1:HALF_W] : stage_in.y[HALF_W-1:0];
      pp = VAL_W'(xp) * VAL_W'(yp);
      weight = 2'(sel_x) + 2'(sel_y);
      pp_shift = PROD_W'(pp) << {weight, 5'b0};
      stage_in_nxt = stage_in;
      stage_in_nxt.acc = stage_in.acc + pp_shift;
   end

   // Advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= stage_vld;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      stage_ff <= stage_in_nxt;
   end

   assign next_vld = vld_ff;
   assign next_out = stage_ff;

endmodule

// File: sv/etfp_mul.sv
// Saturating fixed-point multiplier built as a chain of partial-product
// cells. Depends on etfp_pkg and etfp_cell.
module etfp_mul import etfp_pkg::*; #(
   parameter int FRAC_BITS = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  logic signed [VAL_W-1:0] in_a,
   input  logic signed [VAL_W-1:0] in_b,
   output logic                    out_vld,
   output logic signed [VAL_W-1:0] out_res
);

   logic               head_vld_ff;
   etfp_mul_stage_type head_ff;
   etfp_mul_stage_type head_in;
   logic               chain_vld [NUM_CELLS+1];
   etfp_mul_stage_type chain [NUM_CELLS+1];
   logic [PROD_W-1:0]  shifted;
   logic [VAL_W-1:0]   rlo;
   logic               rhi_nz;
   logic signed [VAL_W-1:0] res_in;
   logic signed [VAL_W-1:0] res_ff;
   logic               out_vld_ff;

   // Split operands into sign and magnitude
   always_comb begin
      head_in.neg = in_a[VAL_W-1] ^ in_b[VAL_W-1];
      head_in.x = in_a[VAL_W-1] ? (~in_a + VAL_W'(1)) : in_a;
      head_in.y = in_b[VAL_W-1] ? (~in_b + VAL_W'(1)) : in_b;
      head_in.acc = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

   assign chain_vld[0] = head_vld_ff;
   assign chain[0] = head_ff;

   // Row of partial-product cells
   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      localparam logic [1:0] SEL = 2'(c);
      etfp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .sel_x     (SEL[1]),
         .sel_y     (SEL[0]),
         .stage_vld (chain_vld[c]),
         .stage_in  (chain[c]),
         .next_vld  (chain_vld[c+1]),
         .next_out  (chain[c+1])
      );
   end

   // Drop fraction bits, saturate and restore the sign
   always_comb begin
      shifted = chain[NUM_CELLS].acc >> FRAC_BITS;
      rlo = shifted[VAL_W-1:0];
      rhi_nz = |shifted[PROD_W-1:VAL_W];
      if (!chain[NUM_CELLS].neg) begin
         res_in = (rhi_nz || rlo[VAL_W-1]) ? SAT_MAX : rlo;
      end else if (rhi_nz || (rlo > VAL_W'(SAT_MIN))) begin
         res_in = SAT_MIN;
      end else begin
         res_in = ~rlo + VAL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= chain_vld[NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_vld = out_vld_ff;
   assign out_res = res_ff;

endmodule

// File: sv/etfp_div.sv
// Restoring divider for the colour scale, one quotient bit per cycle.
// Depends on etfp_pkg.
module etfp_div import etfp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quot
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic [DIV_W-1:0]      quot_ff;
   logic [CNT_W:0]        trial;
   logic [CNT_W:0]        diff;
   logic                  fits;

   // Trial subtract of the next partial remainder
   always_comb begin
      trial = {rem_ff, quot_ff[DIV_W-1]};
      diff = trial - {1'b0, divisor};
      fits = trial >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff <= '0;
            quot_ff <= dividend;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quot_ff <= {quot_ff[DIV_W-2:0], fits};
            step_ff <= step_ff + DIV_STEP_W'(1);
            if (step_ff == DIV_STEP_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: sv/escape_time_fractal_point_unit.sv
// Escape-time fractal point unit: iterates z = z^exponent + addend for one
// plane point. Depends on etfp_pkg, etfp_mul (with etfp_cell) and etfp_div.
//
// Usage:
//   req_* carries one point transaction (mode, point, resume z and count);
//   rsp_* returns final z, iteration count and pixel colour, one per request.
//   csr_we/csr_index/csr_wdata write the configuration registers; write
//   them only while no transaction is in flight.
// Sequence:
//   Each iteration runs a limit check, the magnitude test, exponent - 1
//   complex multiplies (none for exponent 0 or 1) and the add. Each phase
//   issues its products to the multiplier chain back to back and waits for
//   all of them to return. The colour step is followed by the divider for
//   counts of 3 or more with a nonzero limit, then the output register is
//   loaded. One point is in work at a time.
// Reset:
//   Synchronous reset empties the unit and loads the register defaults
//   (limit 64, exponent 2, constant zero, palette shift zero).
// Stall:
//   A finished result sits in the output register until rsp_ready; the unit
//   takes the next request meanwhile and holds its own result until then.
module escape_time_fractal_point_unit import etfp_pkg::*; #(
   parameter int FRAC_BITS = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic signed [VAL_W-1:0] req_point_re,
   input  logic signed [VAL_W-1:0] req_point_im,
   input  logic signed [VAL_W-1:0] req_resume_re,
   input  logic signed [VAL_W-1:0] req_resume_im,
   input  logic [CNT_W-1:0]        req_resume_count,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_final_re,
   output logic signed [VAL_W-1:0] rsp_final_im,
   output logic [CNT_W-1:0]        rsp_iter_count,
   output logic [COLOR_W-1:0]      rsp_pixel_color,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [VAL_W-1:0]        csr_wdata
);

   localparam logic signed [VAL_W-1:0] FIX_FOUR = VAL_W'(4) << FRAC_BITS;
   localparam logic signed [VAL_W-1:0] FIX_ONE = VAL_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_MAG, S_POW, S_ADD, S_COLOR, S_DIV, S_DONE
   } state_type;

   state_type state_ff;

   // Configuration
   logic [CNT_W-1:0]        max_iter_ff;
   logic [3:0]              exponent_ff;
   logic signed [VAL_W-1:0] const_re_ff;
   logic signed [VAL_W-1:0] const_im_ff;
   logic [5:0]              palette_ff;

   // Working point
   logic signed [VAL_W-1:0] z_re_ff;
   logic signed [VAL_W-1:0] z_im_ff;
   logic signed [VAL_W-1:0] w_re_ff;
   logic signed [VAL_W-1:0] w_im_ff;
   logic signed [VAL_W-1:0] add_re_ff;
   logic signed [VAL_W-1:0] add_im_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [3:0]              pw_ff;
   logic [2:0]              iss_ff;
   logic [2:0]              rcv_ff;
   logic signed [VAL_W-1:0] r_ff [NUM_CELLS];
   logic [COLOR_W-1:0]      color_ff;

   // Output register
   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] out_re_ff;
   logic signed [VAL_W-1:0] out_im_ff;
   logic [CNT_W-1:0]        out_count_ff;
   logic [COLOR_W-1:0]      out_color_ff;

   // Multiplier and divider hookup
   logic                    mul_vld;
   logic signed [VAL_W-1:0] mul_a;
   logic signed [VAL_W-1:0] mul_b;
   logic                    mul_out_vld;
   logic signed [VAL_W-1:0] mul_res;
   logic                    div_start;
   logic                    div_done;
   logic [DIV_W-1:0]        div_quot;

   // Combined terms
   logic signed [VAL_W-1:0] mag2;
   logic signed [VAL_W-1:0] prod_re;
   logic signed [VAL_W-1:0] prod_im;
   logic [25:0]             color_off;
   logic [DIV_W:0]          color_sum;
   logic [COLOR_W-1:0]      color_in;

   // Issue products in order for the current phase
   always_comb begin
      mul_vld = ((state_ff == S_MAG) && (iss_ff < 3'd2)) ||
                ((state_ff == S_POW) && (iss_ff < 3'd4));
      mul_a = z_re_ff;
      mul_b = z_re_ff;
      if (state_ff == S_MAG) begin
         mul_a = iss_ff[0] ? z_im_ff : z_re_ff;
         mul_b = mul_a;
      end else begin
         case (iss_ff[1:0])
            2'd0: begin mul_a = w_re_ff; mul_b = z_re_ff; end
            2'd1: begin mul_a = w_im_ff; mul_b = z_im_ff; end
            2'd2: begin mul_a = w_re_ff; mul_b = z_im_ff; end
            2'd3: begin mul_a = w_im_ff; mul_b = z_re_ff; end
            default: begin mul_a = w_re_ff; mul_b = z_re_ff; end
         endcase
      end
   end

   etfp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (mul_vld),
      .in_a    (mul_a),
      .in_b    (mul_b),
      .out_vld (mul_out_vld),
      .out_res (mul_res)
   );

   assign div_start = (state_ff == S_COLOR) && (count_ff >= COLOR_MIN_COUNT) &&
                      (max_iter_ff != '0);

   etfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({count_ff, COLOR_SHIFT'(0)}),
      .divisor  (max_iter_ff),
      .done     (div_done),
      .quot     (div_quot)
   );

   // Combine collected products and the colour offset
   always_comb begin
      mag2 = sat_add(r_ff[0], r_ff[1]);
      prod_re = sat_sub(r_ff[0], r_ff[1]);
      prod_im = sat_add(r_ff[2], r_ff[3]);
      color_off = (palette_ff == '0) ? '0 :
                  26'((32'(palette_ff) - 32'd1) * 32'(COLOR_STEP));
      color_sum = {1'b0, div_quot} + (DIV_W + 1)'(color_off);
      color_in = (color_sum > (DIV_W + 1)'(COLOR_MAX)) ? COLOR_MAX
                                                       : color_sum[COLOR_W-1:0];
   end

   // Sequencer, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         iss_ff <= '0;
         rcv_ff <= '0;
         max_iter_ff <= 16'd64;
         exponent_ff <= 4'd2;
         const_re_ff <= '0;
         const_im_ff <= '0;
         palette_ff <= '0;
      end else begin
         // Take register writes
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_ITER: max_iter_ff <= csr_wdata[CNT_W-1:0];
               CSR_EXPONENT: exponent_ff <= csr_wdata[3:0];
               CSR_CONST_RE: const_re_ff <= csr_wdata;
               CSR_CONST_IM: const_im_ff <= csr_wdata;
               CSR_PALETTE:  palette_ff <= csr_wdata[5:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         // Count issued products and collect returned ones
         if (mul_vld) begin
            iss_ff <= iss_ff + 3'd1;
         end
         if (mul_out_vld) begin
            r_ff[rcv_ff[1:0]] <= mul_res;
            rcv_ff <= rcv_ff + 3'd1;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  add_re_ff <= req_mode ? req_point_re : const_re_ff;
                  add_im_ff <= req_mode ? req_point_im : const_im_ff;
                  if (req_resume_count == '0) begin
                     z_re_ff <= req_mode ? const_re_ff : req_point_re;
                     z_im_ff <= req_mode ? const_im_ff : req_point_im;
                  end else begin
                     z_re_ff <= req_resume_re;
                     z_im_ff <= req_resume_im;
                  end
                  count_ff <= req_resume_count;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               iss_ff <= '0;
               rcv_ff <= '0;
               state_ff <= (count_ff >= max_iter_ff) ? S_COLOR : S_MAG;
            end
            S_MAG: begin
               if (rcv_ff == 3'd2) begin
                  iss_ff <= '0;
                  rcv_ff <= '0;
                  pw_ff <= exponent_ff - 4'd1;
                  if (mag2 >= FIX_FOUR) begin
                     state_ff <= S_COLOR;
                  end else if (exponent_ff == 4'd0) begin
                     w_re_ff <= FIX_ONE;
                     w_im_ff <= '0;
                     state_ff <= S_ADD;
                  end else begin
                     w_re_ff <= z_re_ff;
                     w_im_ff <= z_im_ff;
                     state_ff <= (exponent_ff == 4'd1) ? S_ADD : S_POW;
                  end
               end
            end
            S_POW: begin
               if (rcv_ff == 3'd4) begin
                  w_re_ff <= prod_re;
                  w_im_ff <= prod_im;
                  iss_ff <= '0;
                  rcv_ff <= '0;
                  pw_ff <= pw_ff - 4'd1;
                  if (pw_ff == 4'd1) begin
                     state_ff <= S_ADD;
                  end
               end
            end
            S_ADD: begin
               z_re_ff <= sat_add(w_re_ff, add_re_ff);
               z_im_ff <= sat_add(w_im_ff, add_im_ff);
               count_ff <= count_ff + CNT_W'(1);
               state_ff <= S_CHECK;
            end
            S_COLOR: begin
               if (count_ff < COLOR_MIN_COUNT) begin
                  color_ff <= '0;
                  state_ff <= S_DONE;
               end else if (max_iter_ff == '0) begin
                  color_ff <= COLOR_MAX;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  color_ff <= color_in;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  out_re_ff <= z_re_ff;
                  out_im_ff <= z_im_ff;
                  out_count_ff <= count_ff;
                  out_color_ff <= color_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_final_re = out_re_ff;
   assign rsp_final_im = out_im_ff;
   assign rsp_iter_count = out_count_ff;
   assign rsp_pixel_color = out_color_ff;

   // Products come back only while a phase waits for them
   a_mul_in_phase: assert property (@(posedge clock) disable iff (reset)
      mul_out_vld |-> (state_ff == S_MAG || state_ff == S_POW))
      else $error("product returned outside a multiply phase");

   // Never collect more products than were issued
   a_rcv_le_iss: assert property (@(posedge clock) disable iff (reset)
      rcv_ff <= iss_ff)
      else $error("more products received than issued");

   // Each add step counts exactly one iteration
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("iteration count did not advance by one");

   // Divider finishes only while the colour waits on it
   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the colour phase");

endmodule

// File: tb/sv/etfp_checker.sv
// Scoreboard for the escape-time fractal point unit: mirrors the registers
// from the write port, predicts each point transaction and checks results.
// Depends on etfp_pkg for widths and register indexes.
module etfp_checker import etfp_pkg::*; #(
   parameter int FRAC_BITS = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_mode,
   input  logic signed [VAL_W-1:0] req_point_re,
   input  logic signed [VAL_W-1:0] req_point_im,
   input  logic signed [VAL_W-1:0] req_resume_re,
   input  logic signed [VAL_W-1:0] req_resume_im,
   input  logic [CNT_W-1:0]        req_resume_count,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [VAL_W-1:0] rsp_final_re,
   input  logic signed [VAL_W-1:0] rsp_final_im,
   input  logic [CNT_W-1:0]        rsp_iter_count,
   input  logic [COLOR_W-1:0]      rsp_pixel_color,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [VAL_W-1:0]        csr_wdata,
   output int                      mismatches,
   output int                      points_pending,
   output int                      points_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [VAL_W-1:0] re;
      logic signed [VAL_W-1:0] im;
   } cplx_t;

   typedef struct {
      logic signed [VAL_W-1:0] re;
      logic signed [VAL_W-1:0] im;
      logic [CNT_W-1:0]        count;
      logic [COLOR_W-1:0]      color;
   } pixel_t;

   // Mirrored register file
   logic [CNT_W-1:0]        limit_q;
   logic [3:0]              power_q;
   logic signed [VAL_W-1:0] kre_q;
   logic signed [VAL_W-1:0] kim_q;
   logic [5:0]              shift_q;

   pixel_t expected_pixels[$];

   function automatic logic signed [VAL_W-1:0] add_clamp(
      input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s > $signed({1'b0, SAT_MAX})) return SAT_MAX;
      if (s < $signed({1'b1, SAT_MIN})) return SAT_MIN;
      return s[VAL_W-1:0];
   endfunction

   function automatic logic signed [VAL_W-1:0] sub_clamp(
      input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] s;
      s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
      if (s > $signed({1'b0, SAT_MAX})) return SAT_MAX;
      if (s < $signed({1'b1, SAT_MIN})) return SAT_MIN;
      return s[VAL_W-1:0];
   endfunction

   // Exact product, magnitude truncated by FRAC_BITS, then clamped
   function automatic logic signed [VAL_W-1:0] fixed_mul(
      input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
      logic             neg;
      logic [VAL_W-1:0] x, y;
      logic [127:0]     p;
      neg = a[VAL_W-1] ^ b[VAL_W-1];
      x = a[VAL_W-1] ? -a : a;
      y = b[VAL_W-1] ? -b : b;
      p = ({64'd0, x} * {64'd0, y}) >> FRAC_BITS;
      if (!neg) return (p > 128'h7FFF_FFFF_FFFF_FFFF) ? SAT_MAX : p[VAL_W-1:0];
      if (p > 128'h8000_0000_0000_0000) return SAT_MIN;
      return -p[VAL_W-1:0];
   endfunction

   function automatic cplx_t cplx_mul(input cplx_t a, input cplx_t b);
      cplx_t r;
      r.re = sub_clamp(fixed_mul(a.re, b.re), fixed_mul(a.im, b.im));
      r.im = add_clamp(fixed_mul(a.re, b.im), fixed_mul(a.im, b.re));
      return r;
   endfunction

   function automatic cplx_t cplx_power(input cplx_t z, input logic [3:0] p);
      cplx_t r;
      if (p == 0) begin
         r.re = 64'sd1 <<< FRAC_BITS;
         r.im = '0;
         return r;
      end
      r = z;
      for (int k = 1; k < p; k++) r = cplx_mul(r, z);
      return r;
   endfunction

   function automatic logic [COLOR_W-1:0] color_of(input int count);
      logic [63:0] c;
      if (count < 3) return '0;
      if (limit_q == 0) return COLOR_MAX;
      c = (64'(count) << COLOR_SHIFT) / limit_q;
      if (shift_q > 0) c += 64'(shift_q - 1) * 64'h0b111f;
      if (c > 64'h7FFF_FFFF) c = 64'h7FFF_FFFF;
      return c[COLOR_W-1:0];
   endfunction

   // Iterate one point until it escapes or hits the limit
   function automatic pixel_t escape_point(
      input logic mode, input cplx_t pt, input cplx_t start, input int count);
      cplx_t                   z, addend, k;
      logic signed [VAL_W-1:0] mag2, four;
      pixel_t                  px;
      four = 64'sd4 <<< FRAC_BITS;
      k.re = kre_q;
      k.im = kim_q;
      addend = mode ? pt : k;
      z = (count == 0) ? (mode ? k : pt) : start;
      while (count < limit_q) begin
         mag2 = add_clamp(fixed_mul(z.re, z.re), fixed_mul(z.im, z.im));
         if (mag2 >= four) break;
         z = cplx_power(z, power_q);
         z.re = add_clamp(z.re, addend.re);
         z.im = add_clamp(z.im, addend.im);
         count++;
      end
      px.re = z.re;
      px.im = z.im;
      px.count = count[CNT_W-1:0];
      px.color = color_of(count);
      return px;
   endfunction

   always @(posedge clock) begin
      cplx_t  pt, st;
      pixel_t want;
      if (reset) begin
         limit_q <= 16'd64;
         power_q <= 4'd2;
         kre_q <= '0;
         kim_q <= '0;
         shift_q <= '0;
         expected_pixels.delete();
         mismatches <= 0;
         points_pending <= 0;
         points_checked <= 0;
      end else begin
         // mirror register writes
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_ITER: limit_q <= csr_wdata[CNT_W-1:0];
               CSR_EXPONENT: power_q <= csr_wdata[3:0];
               CSR_CONST_RE: kre_q <= csr_wdata;
               CSR_CONST_IM: kim_q <= csr_wdata;
               CSR_PALETTE:  shift_q <= csr_wdata[5:0];
               default: ;
            endcase
         end
         // predict each accepted point transaction
         if (req_valid && req_ready) begin
            pt.re = req_point_re;
            pt.im = req_point_im;
            st.re = req_resume_re;
            st.im = req_resume_im;
            expected_pixels.push_back(escape_point(req_mode, pt, st,
                                                   int'(req_resume_count)));
         end
         // compare each accepted result transaction with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result transaction with nothing expected", $realtime);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (want.re !== rsp_final_re || want.im !== rsp_final_im ||
                   want.count !== rsp_iter_count || want.color !== rsp_pixel_color) begin
                  if (mismatches < 10) begin
                     $display("%0t: mismatch re %h/%h im %h/%h", $realtime,
                              want.re, rsp_final_re, want.im, rsp_final_im);
                     $display("   count %0d/%0d color %h/%h (expected/actual)",
                              want.count, rsp_iter_count, want.color, rsp_pixel_color);
                  end
                  mismatches <= mismatches + 1;
               end
            end
            points_checked <= points_checked + 1;
         end
         points_pending <= expected_pixels.size();
      end
   end
endmodule

// File: tb/sv/tb.sv
// Top of the fractal point unit testbench: clock, reset, register phases,
// point stimulus and result back-pressure. Depends on etfp_pkg, the unit
// and etfp_checker.
module tb import etfp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_mode = 1'b0;
   logic signed [VAL_W-1:0] req_point_re = '0;
   logic signed [VAL_W-1:0] req_point_im = '0;
   logic signed [VAL_W-1:0] req_resume_re = '0;
   logic signed [VAL_W-1:0] req_resume_im = '0;
   logic [CNT_W-1:0]        req_resume_count = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_final_re;
   logic signed [VAL_W-1:0] rsp_final_im;
   logic [CNT_W-1:0]        rsp_iter_count;
   logic [COLOR_W-1:0]      rsp_pixel_color;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [VAL_W-1:0]        csr_wdata = '0;
   int                      mismatches, points_pending, points_checked;

   localparam logic signed [VAL_W-1:0] ONE = 64'sd1 <<< 48;

   int  points_sent = 0;
   int  phases_run = 0;
   logic no_gaps = 1'b0;
   logic wide_only = 1'b0;
   logic [CNT_W-1:0] cur_limit = 16'd64;

   escape_time_fractal_point_unit uut (.*);
   etfp_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hard stop
   initial begin
      #50ms;
      $display("timeout");
      $display("tb failed");
      $finish;
   end

   // result back-pressure: short and long stalls, with stall-free stretches
   initial begin
      int r;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(50, 300)) @(posedge clock);
         end else if (r < 65) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (r < 95 ? $urandom_range(1, 4) : $urandom_range(20, 150))
               @(posedge clock);
         end
      end
   end

   function automatic logic signed [VAL_W-1:0] any64();
      return {$urandom, $urandom};
   endfunction

   // mostly values within |x| < 2, some full range, some extremes
   function automatic logic signed [VAL_W-1:0] coord();
      int r;
      r = $urandom_range(0, 99);
      if (wide_only || r < 15) return any64();
      if (r < 20) return r[0] ? SAT_MAX : SAT_MIN;
      return any64() >>> 14;
   endfunction

   // drive one register write; the caller drops the enable afterwards
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // wait for the unit to drain, then load a full register setting
   task automatic load_setting(input logic [CNT_W-1:0] lim, input logic [3:0] pw,
                               input logic [VAL_W-1:0] kre, input logic [VAL_W-1:0] kim,
                               input logic [5:0] sh);
      req_valid <= 1'b0;
      while (points_pending != 0 || points_checked != points_sent) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write(CSR_MAX_ITER, lim);
      csr_write(CSR_EXPONENT, pw);
      csr_write(CSR_CONST_RE, kre);
      csr_write(CSR_CONST_IM, kim);
      csr_write(CSR_PALETTE, sh);
      csr_we <= 1'b0;
      cur_limit = lim;
      phases_run++;
   endtask

   // present one point transaction and hold it until accepted
   task automatic send_point(input logic mode, input logic signed [VAL_W-1:0] pre,
                             input logic signed [VAL_W-1:0] pim,
                             input logic signed [VAL_W-1:0] zre,
                             input logic signed [VAL_W-1:0] zim,
                             input logic [CNT_W-1:0] cnt);
      int r, gap;
      r = $urandom_range(0, 99);
      gap = no_gaps ? 0 : (r < 60 ? $urandom_range(0, 2) :
                          r < 93 ? $urandom_range(3, 8) : $urandom_range(20, 80));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_point_re <= pre;
      req_point_im <= pim;
      req_resume_re <= zre;
      req_resume_im <= zim;
      req_resume_count <= cnt;
      do @(posedge clock); while (!(req_valid && req_ready));
      points_sent++;
   endtask

   task automatic random_points(input int n);
      int r;
      logic [CNT_W-1:0] cnt;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (wide_only) cnt = r < 30 ? 16'd0 : 16'($urandom_range(65000, 65535));
         else if (r < 55) cnt = '0;
         else if (r < 85) cnt = 16'($urandom_range(1, cur_limit));
         else if (r < 95) cnt = 16'($urandom_range(cur_limit, 65535));
         else cnt = 16'($urandom) | 16'h8000;
         send_point(1'($urandom_range(0, 1)), coord(), coord(), coord(), coord(), cnt);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed points at reset defaults
      send_point(1'b1, '0, '0, '0, '0, '0);
      send_point(1'b0, '0, '0, '0, '0, '0);
      send_point(1'b1, -ONE, '0, '0, '0, '0);
      send_point(1'b1, ONE >>> 2, ONE >>> 1, '0, '0, '0);
      send_point(1'b0, ONE >>> 1, -(ONE >>> 1), '0, '0, '0);
      send_point(1'b1, SAT_MAX, SAT_MAX, '0, '0, '0);
      send_point(1'b1, SAT_MIN, SAT_MIN, '0, '0, '0);
      send_point(1'b0, SAT_MAX, SAT_MIN, '0, '0, '0);
      send_point(1'b0, '0, '0, SAT_MIN, SAT_MAX, 16'd5);
      send_point(1'b1, ONE >>> 3, '0, ONE >>> 2, ONE >>> 2, 16'd10);
      send_point(1'b1, '0, '0, ONE, ONE, 16'd64);
      send_point(1'b0, '0, '0, ONE, -ONE, 16'hFFFF);
      send_point(1'b1, -(ONE >>> 1), ONE >>> 1, '0, '0, 16'd63);
      send_point(1'b0, -ONE, '0, ONE >>> 4, '0, 16'd1);
      send_point(1'b1, -(ONE <<< 1), '0, '0, '0, '0);
      send_point(1'b1, ONE <<< 1, '0, '0, '0, '0);

      // register phases, extremes among them
      load_setting(16'd16, 4'd2, ONE >>> 2, -(ONE >>> 3), 6'd1);
      random_points(150);
      load_setting(16'd1, 4'd3, any64() >>> 14, any64() >>> 14, 6'd63);
      random_points(90);
      load_setting(16'd0, 4'd0, '0, ONE >>> 1, 6'd5);
      send_point(1'b0, '0, '0, '0, '0, 16'd3);
      send_point(1'b1, '0, '0, '0, '0, 16'd2);
      random_points(40);
      load_setting(16'd8, 4'd1, -(ONE >>> 1), ONE >>> 2, 6'd0);
      no_gaps = 1'b1;
      random_points(100);
      no_gaps = 1'b0;
      load_setting(16'd12, 4'd15, ONE >>> 3, ONE >>> 4, 6'd32);
      random_points(35);
      load_setting(16'd65535, 4'd8, SAT_MAX, SAT_MIN, 6'd63);
      wide_only = 1'b1;
      send_point(1'b0, '0, '0, ONE, ONE, 16'd65534);
      random_points(30);
      wide_only = 1'b0;
      load_setting(16'd5, 4'd4, SAT_MIN, SAT_MAX, 6'd2);
      random_points(150);
      load_setting(16'd32, 4'd2, any64() >>> 14, any64() >>> 14, 6'd17);
      random_points(110);

      // drain, then let the pipeline settle
      req_valid <= 1'b0;
      while (points_pending != 0 || points_checked != points_sent) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("%0d points sent, %0d results checked over %0d register settings",
               points_sent, points_checked, phases_run + 1);
      if (mismatches == 0 && points_pending == 0 && points_checked == points_sent) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb failed");
      end
      $finish;
   end
endmodule
